// File: rtl/irpw_pkg.sv
// Shared types and constants for the IR pulse-width frame decoder.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package irpw_pkg;

  // Frame geometry and sync threshold.
  localparam int unsigned FRAME_BITS = 24;
  localparam int unsigned CNT_W      = $clog2(FRAME_BITS + 1);
  localparam int unsigned WIDTH_W    = 16;
  localparam logic [WIDTH_W-1:0] SYNC_MIN_US = 16'd10000;

  // Output field widths, fixed by the interface.
  localparam int unsigned FRAME_W = 24;
  localparam int unsigned KEY_W   = 8;

  // Configuration port.
  localparam int unsigned CFG_INDEX_W = 8;
  localparam int unsigned NUM_REGS    = 8;
  localparam logic [CFG_INDEX_W-1:0] REG_ZERO_HIGH_MIN = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ZERO_HIGH_MAX = 8'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_ZERO_LOW_MIN  = 8'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_ZERO_LOW_MAX  = 8'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_ONE_HIGH_MIN  = 8'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_ONE_HIGH_MAX  = 8'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_ONE_LOW_MIN   = 8'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_ONE_LOW_MAX   = 8'd7;

  // Queue between the classifier and the frame sequencer (power of two).
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Status codes.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_SYNC = 2'd1;
  localparam logic [1:0] ST_BAD_HIGH = 2'd2;
  localparam logic [1:0] ST_BAD_LOW  = 2'd3;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_HIGH = 2'd1,
    PH_LOW  = 2'd2
  } phase_e;

  typedef struct packed {
    logic               pulse_level;
    logic [WIDTH_W-1:0] pulse_width;
    logic               timed_out;
  } pulse_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [FRAME_W-1:0] frame;
    logic [KEY_W-1:0]   key_code;
  } result_t;

  // Classified pulse: level plus the outcome of every window check.
  typedef struct packed {
    logic level;
    logic sync_ok;
    logic zero_high_ok;
    logic one_high_ok;
    logic zero_low_ok;
    logic one_low_ok;
  } token_t;

endpackage

`default_nettype wire

// File: rtl/ir_pulse_width_frame_decoder_core.sv
// Top level of the IR pulse-width frame decoder.
// Depends on irpw_pkg, irpw_front, irpw_queue and irpw_back.
`default_nettype none

// The decoder takes one measured line pulse per word (level, width in
// microseconds, timeout flag) and returns at most one result word per pulse.
// A low pulse wider than the sync minimum starts a frame; every bit is then a
// high pulse followed by a low pulse, each checked against open-interval
// windows held in eight 16-bit configuration registers (zero high min/max,
// zero low min/max, one high min/max, one low min/max; minima reset to 0,
// maxima to 65535). When both high windows match, the zero window wins. After
// FRAME_BITS bits a frame word is returned with status ok, the first bit in
// the MSB of the bits used and the last byte in key_code. A short low pulse
// while idle returns bad sync, a pulse that fails its high or low check
// returns bad high or bad low; every error word carries zero data and the
// decoder drops back to idle at once. High pulses while idle are ignored and
// the timeout flag does not change classification. Throughput is one pulse
// word per clock cycle: the front classifies a pulse with nine parallel
// compares in the cycle it is accepted and writes it into a two-entry queue;
// the back sequencer drains one entry per cycle into a single output
// register whenever that register is free or being emptied, so a result is
// registered at the same edge at which its pulse leaves the queue, and the
// input only stalls once the queue fills while the output is held.
// Configuration writes are always accepted and take effect on the next
// pulse; indexes beyond seven are ignored.

module ir_pulse_width_frame_decoder_core
  import irpw_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  // Pulse input channel.
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  input  wire pulse_t                 in_pulse_i,
  // Result output channel.
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  output result_t                     out_result_o,
  // Configuration write channel.
  input  wire logic                   cfg_valid_i,
  output logic                        cfg_ready_o,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index_i,
  input  wire logic [WIDTH_W-1:0]     cfg_value_i
);

  token_t front_token;
  token_t queue_token;
  logic   queue_full;
  logic   queue_valid;
  logic   queue_pop;
  logic   push;

  // The register file never stalls a write.
  assign cfg_ready_o = 1'b1;

  // A pulse word is accepted whenever the queue has a free slot.
  assign in_ready_o = !queue_full;
  assign push       = in_valid_i && in_ready_o;

  irpw_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_value_i (cfg_value_i),
    .pulse_i     (in_pulse_i),
    .token_o     (front_token)
  );

  irpw_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (front_token),
    .full_o      (queue_full),
    .valid_o     (queue_valid),
    .pop_i       (queue_pop),
    .pop_data_o  (queue_token)
  );

  // The sequencer keeps the frame state and owns the output register.
  irpw_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .tok_valid_i  (queue_valid),
    .tok_i        (queue_token),
    .tok_pop_o    (queue_pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_result_o (out_result_o)
  );

endmodule

`default_nettype wire

// File: rtl/irpw_front.sv
// Front end: window registers and pulse classification.
// Depends on irpw_pkg.
`default_nettype none

module irpw_front
  import irpw_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_valid_i,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index_i,
  input  wire logic [WIDTH_W-1:0]     cfg_value_i,
  input  wire pulse_t                 pulse_i,
  output token_t                      token_o
);

  logic [WIDTH_W-1:0] win_q [NUM_REGS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        // Odd registers are upper bounds and reset fully open.
        win_q[i] <= (i % 2 == 1) ? {WIDTH_W{1'b1}} : '0;
      end
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_ZERO_HIGH_MIN: win_q[0] <= cfg_value_i;
        REG_ZERO_HIGH_MAX: win_q[1] <= cfg_value_i;
        REG_ZERO_LOW_MIN:  win_q[2] <= cfg_value_i;
        REG_ZERO_LOW_MAX:  win_q[3] <= cfg_value_i;
        REG_ONE_HIGH_MIN:  win_q[4] <= cfg_value_i;
        REG_ONE_HIGH_MAX:  win_q[5] <= cfg_value_i;
        REG_ONE_LOW_MIN:   win_q[6] <= cfg_value_i;
        REG_ONE_LOW_MAX:   win_q[7] <= cfg_value_i;
        default: ;
      endcase
    end
  end

  // All windows are open intervals.
  always_comb begin
    token_o.level        = pulse_i.pulse_level;
    token_o.sync_ok      = pulse_i.pulse_width > SYNC_MIN_US;
    token_o.zero_high_ok = (pulse_i.pulse_width > win_q[0]) && (pulse_i.pulse_width < win_q[1]);
    token_o.zero_low_ok  = (pulse_i.pulse_width > win_q[2]) && (pulse_i.pulse_width < win_q[3]);
    token_o.one_high_ok  = (pulse_i.pulse_width > win_q[4]) && (pulse_i.pulse_width < win_q[5]);
    token_o.one_low_ok   = (pulse_i.pulse_width > win_q[6]) && (pulse_i.pulse_width < win_q[7]);
  end

endmodule

`default_nettype wire

// File: rtl/irpw_queue.sv
// Short first-in first-out queue of classified pulses.
// Depends on irpw_pkg.
`default_nettype none

module irpw_queue
  import irpw_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   push_i,
  input  wire token_t push_data_i,
  output logic        full_o,
  output logic        valid_o,
  input  wire logic   pop_i,
  output token_t      pop_data_o
);

  token_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0]   count_q, count_d;

  assign full_o     = count_q == QCNT_W'(QUEUE_DEPTH);
  assign valid_o    = count_q != '0;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + QCNT_W'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      end
      count_q <= count_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/irpw_back.sv
// Back end: frame sequencer and output register.
// Depends on irpw_pkg; consumes tokens from irpw_queue.
`default_nettype none

module irpw_back
  import irpw_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   tok_valid_i,
  input  wire token_t tok_i,
  output logic        tok_pop_o,
  output logic        out_valid_o,
  input  wire logic   out_ready_i,
  output result_t     out_result_o
);

  phase_e                phase_q, phase_d;
  logic                  pending_q, pending_d;
  logic [CNT_W-1:0]      count_q, count_d;
  logic [FRAME_BITS-1:0] shift_q, shift_d;
  logic [FRAME_BITS-1:0] shifted;
  logic [CNT_W-1:0]      count_inc;
  logic                  low_ok;

  logic                  emit;
  logic [1:0]            emit_status;
  logic                  emit_frame;

  logic                  out_valid_q;
  result_t               out_q;

  // A token is taken whenever the output register is free or being emptied.
  assign tok_pop_o = tok_valid_i && (!out_valid_q || out_ready_i);

  assign shifted   = {shift_q[FRAME_BITS-2:0], pending_q};
  assign count_inc = count_q + CNT_W'(1);
  assign low_ok    = pending_q ? tok_i.one_low_ok : tok_i.zero_low_ok;

  // Next state.
  always_comb begin
    phase_d   = phase_q;
    pending_d = pending_q;
    count_d   = count_q;
    shift_d   = shift_q;
    if (tok_pop_o) begin
      case (phase_q)
        PH_HIGH: begin
          if (tok_i.level && tok_i.zero_high_ok) begin
            pending_d = 1'b0;
            phase_d   = PH_LOW;
          end else if (tok_i.level && tok_i.one_high_ok) begin
            pending_d = 1'b1;
            phase_d   = PH_LOW;
          end else begin
            phase_d = PH_IDLE;
          end
        end
        PH_LOW: begin
          if (!tok_i.level && low_ok && count_inc != CNT_W'(FRAME_BITS)) begin
            shift_d = shifted;
            count_d = count_inc;
            phase_d = PH_HIGH;
          end else begin
            phase_d = PH_IDLE;
          end
        end
        default: begin
          phase_d = PH_IDLE;
          if (!tok_i.level && tok_i.sync_ok) begin
            phase_d = PH_HIGH;
          end
        end
      endcase
      // Leaving for idle or starting a frame both clear the frame state.
      if (phase_d != PH_LOW && phase_d != PH_HIGH || phase_q != PH_LOW && phase_q != PH_HIGH) begin
        pending_d = 1'b0;
        count_d   = '0;
        shift_d   = '0;
      end
    end
  end

  // Result generation.
  always_comb begin
    emit        = 1'b0;
    emit_status = ST_OK;
    emit_frame  = 1'b0;
    if (tok_pop_o) begin
      case (phase_q)
        PH_HIGH: begin
          if (!(tok_i.level && (tok_i.zero_high_ok || tok_i.one_high_ok))) begin
            emit        = 1'b1;
            emit_status = ST_BAD_HIGH;
          end
        end
        PH_LOW: begin
          if (tok_i.level || !low_ok) begin
            emit        = 1'b1;
            emit_status = ST_BAD_LOW;
          end else if (count_inc == CNT_W'(FRAME_BITS)) begin
            emit        = 1'b1;
            emit_status = ST_OK;
            emit_frame  = 1'b1;
          end
        end
        default: begin
          if (!tok_i.level && !tok_i.sync_ok) begin
            emit        = 1'b1;
            emit_status = ST_BAD_SYNC;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      pending_q   <= 1'b0;
      count_q     <= '0;
      shift_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      pending_q <= pending_d;
      count_q   <= count_d;
      shift_q   <= shift_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q.status   <= emit_status;
      out_q.frame    <= emit_frame ? FRAME_W'(shifted) : '0;
      out_q.key_code <= emit_frame ? shifted[KEY_W-1:0] : '0;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_result_o = out_q;

endmodule

`default_nettype wire

// File: tb/tb_ir_pulse_width_frame_decoder_core.sv
// Self-checking testbench for ir_pulse_width_frame_decoder_core.
// Holds a frame checker class with its own decoder predictor; depends on irpw_pkg and the RTL.
`default_nettype none

module tb_ir_pulse_width_frame_decoder_core;
  timeunit 1ns;
  timeprecision 1ps;

  import irpw_pkg::*;

  // Cycles the block may still spend on words that leave no result behind
  // (two queue entries plus the output register, with margin).
  localparam int unsigned LATENCY_CYCLES = 8;
  localparam int unsigned HOLD_CYCLES    = 400;
  localparam logic [FRAME_W-1:0] FRAME_MASK = FRAME_W'((64'd1 << FRAME_BITS) - 1);
  // Indexes past the register file; writes there must be ignored.
  localparam logic [CFG_INDEX_W-1:0] CFG_INDEX_UNUSED_FIRST = CFG_INDEX_W'(NUM_REGS);
  localparam logic [CFG_INDEX_W-1:0] CFG_INDEX_UNUSED_LAST  = '1;

  // The checker keeps its own copy of the window registers and of the
  // decoder state, predicts the result word of every accepted pulse word and
  // compares the result words that come out against those predictions.
  class frame_checker;
    logic [WIDTH_W-1:0] win [NUM_REGS];
    phase_e             dec_phase;
    logic               next_bit;
    int unsigned        bit_count;
    logic [FRAME_W-1:0] shift_bits;
    result_t            pending_frames [$];
    int unsigned        mismatches;
    int unsigned        predicted;
    int unsigned        pulses_used;

    function new();
      win[REG_ZERO_HIGH_MIN] = '0;
      win[REG_ZERO_HIGH_MAX] = '1;
      win[REG_ZERO_LOW_MIN]  = '0;
      win[REG_ZERO_LOW_MAX]  = '1;
      win[REG_ONE_HIGH_MIN]  = '0;
      win[REG_ONE_HIGH_MAX]  = '1;
      win[REG_ONE_LOW_MIN]   = '0;
      win[REG_ONE_LOW_MAX]   = '1;
      clear_frame();
      mismatches  = 0;
      predicted   = 0;
      pulses_used = 0;
    endfunction

    function void clear_frame();
      dec_phase  = PH_IDLE;
      next_bit   = 1'b0;
      bit_count  = 0;
      shift_bits = '0;
    endfunction

    // Open interval: both bounds are excluded.
    function bit in_window(logic [WIDTH_W-1:0] w, logic [WIDTH_W-1:0] lo,
                           logic [WIDTH_W-1:0] hi);
      return (w > lo) && (w < hi);
    endfunction

    function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [WIDTH_W-1:0] val);
      if (idx < NUM_REGS) win[idx] = val;
    endfunction

    function void emit(logic [1:0] st, logic [FRAME_W-1:0] fr);
      result_t r;
      r.status   = st;
      r.frame    = fr;
      r.key_code = fr[KEY_W-1:0];
      pending_frames.push_back(r);
      predicted++;
      clear_frame();
    endfunction

    function void take_pulse(pulse_t p);
      case (dec_phase)
        PH_HIGH: begin
          pulses_used++;
          // The zero window is tried first, so it wins when both match.
          if (p.pulse_level && in_window(p.pulse_width, win[REG_ZERO_HIGH_MIN],
                                         win[REG_ZERO_HIGH_MAX])) begin
            next_bit  = 1'b0;
            dec_phase = PH_LOW;
          end else if (p.pulse_level && in_window(p.pulse_width, win[REG_ONE_HIGH_MIN],
                                                  win[REG_ONE_HIGH_MAX])) begin
            next_bit  = 1'b1;
            dec_phase = PH_LOW;
          end else begin
            emit(ST_BAD_HIGH, '0);
          end
        end
        PH_LOW: begin
          pulses_used++;
          if (p.pulse_level) begin
            emit(ST_BAD_LOW, '0);
          end else if (!(next_bit ?
                         in_window(p.pulse_width, win[REG_ONE_LOW_MIN], win[REG_ONE_LOW_MAX]) :
                         in_window(p.pulse_width, win[REG_ZERO_LOW_MIN],
                                   win[REG_ZERO_LOW_MAX]))) begin
            emit(ST_BAD_LOW, '0);
          end else begin
            shift_bits = ((shift_bits << 1) | FRAME_W'(next_bit)) & FRAME_MASK;
            bit_count++;
            if (bit_count >= FRAME_BITS) emit(ST_OK, shift_bits);
            else dec_phase = PH_HIGH;
          end
        end
        default: begin
          dec_phase = PH_IDLE;
          // High words while idle are dropped without a result.
          if (!p.pulse_level) begin
            pulses_used++;
            if (p.pulse_width > SYNC_MIN_US) begin
              clear_frame();
              dec_phase = PH_HIGH;
            end else begin
              emit(ST_BAD_SYNC, '0);
            end
          end
        end
      endcase
    endfunction

    task report(string what);
      mismatches++;
      if (mismatches <= 100) $display("mismatch at %0t: %s", $realtime, what);
    endtask

    task check_word(result_t got);
      result_t want;
      if (pending_frames.size() == 0) begin
        report($sformatf("result word %h with nothing predicted", got));
        return;
      end
      want = pending_frames.pop_front();
      if (got.status !== want.status)
        report($sformatf("status %0d, predicted %0d", got.status, want.status));
      if (got.frame !== want.frame)
        report($sformatf("frame %h, predicted %h", got.frame, want.frame));
      if (got.key_code !== want.key_code)
        report($sformatf("key_code %h, predicted %h", got.key_code, want.key_code));
    endtask
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_ready;
  pulse_t                 in_pulse;
  logic                   out_valid;
  logic                   out_ready;
  result_t                out_result;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [WIDTH_W-1:0]     cfg_value;

  frame_checker frames;

  // Random idling on both sides; switched off for the last stretch.
  bit          idling_on = 1'b1;
  // The main thread bumps hold_req to ask the receiver for a long stall;
  // the receiver counts the stall down itself.
  int unsigned hold_req  = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;
  int unsigned stall_left = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  ir_pulse_width_frame_decoder_core u_top (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .in_pulse_i   (in_pulse),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .out_result_o (out_result),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_value_i  (cfg_value)
  );

  // Receiver: ready changes at the falling edge only. A requested hold takes
  // priority over the short random stall bursts.
  always @(negedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      out_ready = 1'b0;
      hold_left--;
    end else if (stall_left > 0) begin
      out_ready = 1'b0;
      stall_left--;
    end else begin
      out_ready = 1'b1;
      if (idling_on && $urandom_range(0, 11) == 0) stall_left = $urandom_range(1, 19);
    end
  end

  // Every result word taken at a rising edge is checked against the oldest
  // prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) frames.check_word(out_result);
  end

  // Hard stop well beyond the slowest correct run.
  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

  function automatic pulse_t mk_pulse(logic level, logic [WIDTH_W-1:0] width, logic tmo);
    pulse_t p;
    p.pulse_level = level;
    p.pulse_width = width;
    p.timed_out   = tmo;
    return p;
  endfunction

  // A width strictly inside (lo, hi); when the window is empty any width goes,
  // which then breaks the frame or decodes another bit.
  function automatic logic [WIDTH_W-1:0] pick_between(logic [WIDTH_W-1:0] lo,
                                                      logic [WIDTH_W-1:0] hi);
    int span;
    span = int'(hi) - int'(lo) - 1;
    if (span >= 1) return WIDTH_W'(int'(lo) + 1 + $urandom_range(0, span - 1));
    return WIDTH_W'($urandom);
  endfunction

  // A high width for a one bit; retries to stay out of the zero window, which
  // would otherwise take the bit.
  function automatic logic [WIDTH_W-1:0] pick_one_high();
    logic [WIDTH_W-1:0] w;
    int                 tries;
    w = pick_between(frames.win[REG_ONE_HIGH_MIN], frames.win[REG_ONE_HIGH_MAX]);
    for (tries = 0; tries < 8; tries++) begin
      if (!frames.in_window(w, frames.win[REG_ZERO_HIGH_MIN], frames.win[REG_ZERO_HIGH_MAX]))
        break;
      w = pick_between(frames.win[REG_ONE_HIGH_MIN], frames.win[REG_ONE_HIGH_MAX]);
    end
    return w;
  endfunction

  // Noise leans on the corners: tiny, huge and near the sync threshold.
  function automatic pulse_t noise_pulse();
    logic [WIDTH_W-1:0] w;
    case ($urandom_range(0, 3))
      0:       w = WIDTH_W'($urandom);
      1:       w = WIDTH_W'($urandom_range(0, 20));
      2:       w = WIDTH_W'(65535 - $urandom_range(0, 20));
      default: w = WIDTH_W'(int'(SYNC_MIN_US) - 1 + $urandom_range(0, 2));
    endcase
    return mk_pulse(1'($urandom), w, 1'($urandom));
  endfunction

  // Offers one pulse word, called at a falling edge; returns at the falling
  // edge after acceptance with valid still high, so back-to-back words never
  // drop valid in between.
  task automatic send_pulse(input pulse_t p);
    if (idling_on && $urandom_range(0, 5) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    in_valid = 1'b1;
    in_pulse = p;
    do @(posedge clk); while (!in_ready);
    frames.take_pulse(p);
    @(negedge clk);
  endtask

  // A sync word and FRAME_BITS bit pairs. When break_at names one of the
  // words, a noise word goes out in its place and the frame stops there.
  task automatic send_frame(input logic [FRAME_W-1:0] data, input int break_at);
    pulse_t p;
    logic   b;
    int     k;
    for (k = 0; k <= 2 * FRAME_BITS; k++) begin
      if (k == 0) begin
        p = mk_pulse(1'b0, WIDTH_W'($urandom_range(int'(SYNC_MIN_US) + 1, 65535)), 1'b0);
      end else begin
        b = data[FRAME_BITS - 1 - (k - 1) / 2];
        if (k % 2 == 1)
          p = mk_pulse(1'b1, b ? pick_one_high() :
                       pick_between(frames.win[REG_ZERO_HIGH_MIN], frames.win[REG_ZERO_HIGH_MAX]),
                       1'b0);
        else
          p = mk_pulse(1'b0, b ?
                       pick_between(frames.win[REG_ONE_LOW_MIN], frames.win[REG_ONE_LOW_MAX]) :
                       pick_between(frames.win[REG_ZERO_LOW_MIN], frames.win[REG_ZERO_LOW_MAX]),
                       1'b0);
      end
      p.timed_out = 1'($urandom);
      if (k == break_at) begin
        send_pulse(noise_pulse());
        return;
      end
      send_pulse(p);
    end
  endtask

  // Lowers valid, waits for every predicted word, then gives words that leave
  // no result time to drain before the registers change.
  task automatic settle_decoder();
    in_valid = 1'b0;
    while (frames.pending_frames.size() != 0) @(posedge clk);
    repeat (LATENCY_CYCLES) @(negedge clk);
  endtask

  task automatic write_cfg(input logic [CFG_INDEX_W-1:0] idx, input logic [WIDTH_W-1:0] val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_value = val;
    do @(posedge clk); while (!cfg_ready);
    frames.write_reg(idx, val);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic write_windows(input logic [WIDTH_W-1:0] zh_lo, zh_hi, zl_lo, zl_hi,
                               input logic [WIDTH_W-1:0] oh_lo, oh_hi, ol_lo, ol_hi);
    write_cfg(REG_ZERO_HIGH_MIN, zh_lo);
    write_cfg(REG_ZERO_HIGH_MAX, zh_hi);
    write_cfg(REG_ZERO_LOW_MIN,  zl_lo);
    write_cfg(REG_ZERO_LOW_MAX,  zl_hi);
    write_cfg(REG_ONE_HIGH_MIN,  oh_lo);
    write_cfg(REG_ONE_HIGH_MAX,  oh_hi);
    write_cfg(REG_ONE_LOW_MIN,   ol_lo);
    write_cfg(REG_ONE_LOW_MAX,   ol_hi);
    // A stray write past the register file must change nothing.
    write_cfg($urandom_range(0, 1) ? CFG_INDEX_UNUSED_FIRST : CFG_INDEX_UNUSED_LAST,
              WIDTH_W'($urandom));
  endtask

  // Mostly narrow, well-formed windows; now and then a fully random pair,
  // which may well be empty.
  task automatic random_windows();
    logic [WIDTH_W-1:0] v [8];
    int                 j;
    int                 lo;
    for (j = 0; j < 8; j += 2) begin
      if ($urandom_range(0, 3) == 0) begin
        v[j]     = WIDTH_W'($urandom);
        v[j + 1] = WIDTH_W'($urandom);
      end else begin
        lo       = $urandom_range(0, 60000);
        v[j]     = WIDTH_W'(lo);
        v[j + 1] = WIDTH_W'((lo + $urandom_range(2, 5000) > 65535) ? 65535 :
                            lo + $urandom_range(2, 5000));
      end
    end
    write_windows(v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7]);
  endtask

  // Random traffic: mostly clean frames with random data, the rest broken
  // frames, stray words and fixed bit patterns. Runs until enough words have
  // been used by the decoder and enough results have been predicted.
  task automatic run_traffic(input int unsigned min_used, input int unsigned min_words);
    int unsigned used0;
    int unsigned words0;
    int unsigned pick;
    used0  = frames.pulses_used;
    words0 = frames.predicted;
    while (frames.pulses_used - used0 < min_used || frames.predicted - words0 < min_words) begin
      pick = $urandom_range(0, 9);
      if (pick <= 5) begin
        send_frame(FRAME_W'($urandom), -1);
      end else if (pick <= 7) begin
        send_frame(FRAME_W'($urandom), $urandom_range(0, 2 * FRAME_BITS));
      end else if (pick == 8) begin
        repeat ($urandom_range(1, 4)) send_pulse(noise_pulse());
      end else begin
        case ($urandom_range(0, 3))
          0:       send_frame('0, -1);
          1:       send_frame(FRAME_MASK, -1);
          2:       send_frame(FRAME_W'(24'hAAAAAA), -1);
          default: send_frame(FRAME_W'(24'h555555), -1);
        endcase
      end
    end
  endtask

  initial begin
    frames    = new();
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_pulse  = '0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_value = '0;
    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    // Directed words on the reset windows (every bound 0 or 65535).
    // A high word while idle is dropped.
    send_pulse(mk_pulse(1'b1, 16'hFFFF, 1'b1));
    // Short low words while idle, the second right at the threshold.
    send_pulse(mk_pulse(1'b0, 16'd0, 1'b0));
    send_pulse(mk_pulse(1'b0, SYNC_MIN_US, 1'b1));
    // Sync just above the threshold, then a high word of zero width, which
    // is outside both open windows.
    send_pulse(mk_pulse(1'b0, SYNC_MIN_US + 16'd1, 1'b0));
    send_pulse(mk_pulse(1'b1, 16'd0, 1'b0));
    // A low word where a high one belongs.
    send_pulse(mk_pulse(1'b0, 16'hFFFF, 1'b1));
    send_pulse(mk_pulse(1'b0, 16'd500, 1'b0));
    // A high word at the saturated width, outside the upper bound.
    send_pulse(mk_pulse(1'b0, 16'hFFFF, 1'b0));
    send_pulse(mk_pulse(1'b1, 16'hFFFF, 1'b0));
    // A high word where a low one belongs.
    send_pulse(mk_pulse(1'b0, 16'd20000, 1'b0));
    send_pulse(mk_pulse(1'b1, 16'd1, 1'b1));
    send_pulse(mk_pulse(1'b1, 16'd1, 1'b0));
    // Bad low words at both ends; the frame stops at once.
    send_pulse(mk_pulse(1'b0, 16'd30000, 1'b0));
    send_pulse(mk_pulse(1'b1, 16'hFFFE, 1'b0));
    send_pulse(mk_pulse(1'b0, 16'd0, 1'b0));
    send_pulse(mk_pulse(1'b0, 16'd30000, 1'b0));
    send_pulse(mk_pulse(1'b1, 16'd100, 1'b0));
    send_pulse(mk_pulse(1'b0, 16'hFFFF, 1'b1));
    settle_decoder();

    // Disjoint windows. The receiver holds off for a long stretch while a
    // run of short sync words fills the queue and stalls the input.
    write_windows(16'd400, 16'd700, 16'd400, 16'd700, 16'd1500, 16'd1800, 16'd1500, 16'd1800);
    hold_req++;
    repeat (30) send_pulse(mk_pulse(1'b0, WIDTH_W'($urandom_range(0, int'(SYNC_MIN_US))),
                                    1'($urandom)));
    run_traffic(40, 2);
    settle_decoder();

    // Overlapping high windows, so the zero window has to win the tie.
    write_windows(16'd400, 16'd800, 16'd400, 16'd800, 16'd600, 16'd1200, 16'd1400, 16'd1900);
    run_traffic(40, 2);
    settle_decoder();

    // Windows pinned to the ends of the width range.
    write_windows(16'd0, 16'd2, 16'd65533, 16'd65535, 16'd65533, 16'd65535, 16'd0, 16'd2);
    run_traffic(40, 2);
    settle_decoder();

    repeat (3) begin
      random_windows();
      run_traffic(40, 2);
      settle_decoder();
    end

    // Back to the reset values, written this time.
    write_windows(16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'd0, 16'hFFFF);
    run_traffic(40, 2);
    settle_decoder();

    // Last stretch at full rate on both sides.
    idling_on = 1'b0;
    write_windows(16'd400, 16'd700, 16'd400, 16'd700, 16'd1500, 16'd1800, 16'd1500, 16'd1800);
    run_traffic(40, 2);
    settle_decoder();

    if (frames.mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
